### hw/rtl/m3c1_pkg.sv
`timescale 1ns / 1ps

package m3c1_pkg;

  localparam int unsigned MaxValuesDefault = 576;

  localparam int unsigned RegionBitsW = 12;
  localparam int unsigned ValueCountW = 10;
  localparam int unsigned QuadW       = 8;
  localparam int unsigned NzEndW      = 10;

  localparam int unsigned CmdDepth = 2;
  localparam int unsigned ResDepth = 4;

  typedef enum logic {
    CmdStart = 1'b0,
    CmdBit   = 1'b1
  } cmd_kind_e;

  typedef enum logic {
    ResQuad    = 1'b0,
    ResSummary = 1'b1
  } res_kind_e;

  typedef struct packed {
    cmd_kind_e              kind;
    logic                   bit_val;
    logic                   table_b;
    logic [RegionBitsW-1:0] region_bits;
    logic [QuadW-1:0]       quads_limit;
  } cmd_t;

  typedef struct packed {
    res_kind_e          kind;
    logic signed [1:0]  val_v;
    logic signed [1:0]  val_w;
    logic signed [1:0]  val_x;
    logic signed [1:0]  val_y;
    logic [QuadW-1:0]   quad_index;
    logic [NzEndW-1:0]  nonzero_end;
    logic               last;
  } res_t;

  typedef struct packed {
    logic first_vld;
    logic second_vld;
    res_t first;
    res_t second;
  } res_wr_t;

endpackage

### hw/rtl/m3c1_front.sv
`timescale 1ns / 1ps

module m3c1_front #(
  parameter int unsigned MaxValues = m3c1_pkg::MaxValuesDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic                                op_i,
  input  logic                                bit_in_i,
  input  logic                                table_b_i,
  input  logic [m3c1_pkg::RegionBitsW-1:0]    region_bits_i,
  input  logic [m3c1_pkg::ValueCountW-1:0]    value_count_i,
  output logic                                cmd_vld_o,
  output m3c1_pkg::cmd_t                      cmd_o,
  input  logic                                cmd_pop_i
);
  import m3c1_pkg::*;

  localparam int unsigned PtrW = $clog2(CmdDepth);
  localparam int unsigned CntW = $clog2(CmdDepth + 1);

  cmd_t                   mem_q [CmdDepth];
  logic [PtrW-1:0]        wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   do_push;
  logic [ValueCountW-1:0] vc_clamp;
  cmd_t                   cmd_in;

  // clamp the value count and turn it into a quad limit
  always_comb begin
    if ({1'b0, value_count_i} > (ValueCountW + 1)'(MaxValues)) begin
      vc_clamp = ValueCountW'(MaxValues);
    end else begin
      vc_clamp = value_count_i;
    end
    cmd_in.kind        = op_i ? CmdBit : CmdStart;
    cmd_in.bit_val     = bit_in_i;
    cmd_in.table_b     = table_b_i;
    cmd_in.region_bits = region_bits_i;
    cmd_in.quads_limit = QuadW'(vc_clamp >> 2);
  end

  assign full      = (cnt_q == CntW'(CmdDepth));
  assign do_push   = push && !full;
  assign cmd_vld_o = (cnt_q != '0);
  assign cmd_o     = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(CmdDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (cmd_pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(CmdDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !cmd_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && cmd_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

### hw/rtl/m3c1_back.sv
`timescale 1ns / 1ps

module m3c1_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_vld_i,
  input  m3c1_pkg::cmd_t    cmd_i,
  output logic              cmd_pop_o,
  input  logic              res_room_i,
  output m3c1_pkg::res_wr_t res_wr_o
);
  import m3c1_pkg::*;

  typedef enum logic [1:0] {
    PhIdle,
    PhCode,
    PhSign
  } phase_e;

  // table A: length in [6:4], pattern in [3:0], indexed by the next six bits
  localparam logic [7:0] CwaTab [64] = '{
    8'h6B, 8'h6F, 8'h6D, 8'h6E, 8'h67, 8'h65, 8'h59, 8'h59,
    8'h56, 8'h56, 8'h53, 8'h53, 8'h5A, 8'h5A, 8'h5C, 8'h5C,
    8'h42, 8'h42, 8'h42, 8'h42, 8'h41, 8'h41, 8'h41, 8'h41,
    8'h44, 8'h44, 8'h44, 8'h44, 8'h48, 8'h48, 8'h48, 8'h48,
    8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10,
    8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10,
    8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10,
    8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10
  };

  function automatic logic signed [1:0] sign_val(input logic       present,
                                                 input logic [3:0] signs,
                                                 input logic [2:0] sidx);
    logic [3:0] sh;
    sh = signs >> sidx;
    if (!present) begin
      return 2'sb00;
    end
    return sh[0] ? 2'sb11 : 2'sb01;
  endfunction

  phase_e              phase_q, phase_d;
  logic                use_b_q, use_b_d;
  logic [5:0]          code_shift_q, code_shift_d;
  logic [2:0]          code_len_q, code_len_d;
  logic [3:0]          pattern_q, pattern_d;
  logic [2:0]          sign_slot_q, sign_slot_d;
  logic [3:0]          signs_q, signs_d;
  logic signed [13:0]  bits_left_q, bits_left_d;
  logic [QuadW-1:0]    quads_done_q, quads_done_d;
  logic [QuadW-1:0]    quads_limit_q, quads_limit_d;
  logic [QuadW-1:0]    nz_cnt_q, nz_cnt_d;
  logic [3:0]          nz_pat_q, nz_pat_d;

  logic                go;
  logic [5:0]          cs_n;
  logic [2:0]          len_n;
  logic [5:0]          a_idx;
  logic [7:0]          a_ent;
  logic                code_done;
  logic [3:0]          code_pat;
  logic [2:0]          code_cost;
  logic signed [13:0]  code_bl;
  logic [3:0]          sgn_n;
  logic [2:0]          slot_n;
  logic [2:0]          ones_q;
  logic                start_cont;

  logic                fin;
  logic [3:0]          fin_pat;
  logic [3:0]          fin_signs;
  logic [2:0]          fin_slot;
  logic signed [13:0]  fin_bl;
  logic [QuadW-1:0]    qd_n;
  logic                fin_cont;
  logic [1:0]          tk_w, tk_x, tk_y;
  logic [NzEndW-1:0]   nz_end;
  res_t                quad_res;
  res_t                sum_res;

  assign go        = cmd_vld_i && res_room_i;
  assign cmd_pop_o = go;

  assign cs_n      = {code_shift_q[4:0], cmd_i.bit_val};
  assign len_n     = code_len_q + 3'd1;
  assign a_idx     = 6'(cs_n << (3'd6 - len_n));
  assign a_ent     = CwaTab[a_idx];
  assign code_done = use_b_q ? (len_n >= 3'd4) : ((a_ent[6:4] == len_n) || (len_n >= 3'd6));
  assign code_pat  = use_b_q ? ~cs_n[3:0] : a_ent[3:0];
  assign code_cost = use_b_q ? 3'd4 : a_ent[6:4];
  assign code_bl   = bits_left_q - signed'(14'(code_cost));
  assign sgn_n     = {signs_q[2:0], cmd_i.bit_val};
  assign slot_n    = sign_slot_q + 3'd1;
  assign ones_q    = 3'(pattern_q[3]) + 3'(pattern_q[2]) + 3'(pattern_q[1]) + 3'(pattern_q[0]);

  assign start_cont = (cmd_i.quads_limit != '0) &&
                      (cmd_i.table_b ? (cmd_i.region_bits >= RegionBitsW'(4))
                                     : (cmd_i.region_bits != '0));

  // quad finish operands
  always_comb begin
    if (phase_q == PhSign) begin
      fin_pat   = pattern_q;
      fin_signs = sgn_n;
      fin_slot  = slot_n;
      fin_bl    = bits_left_q - 14'sd1;
    end else begin
      fin_pat   = code_pat;
      fin_signs = '0;
      fin_slot  = '0;
      fin_bl    = code_bl;
    end
  end

  assign qd_n     = quads_done_q + 1'b1;
  assign fin_cont = (qd_n < quads_limit_q) &&
                    (use_b_q ? (fin_bl >= 14'sd4) : (fin_bl > 14'sd0));
  assign tk_w     = 2'(fin_pat[3]);
  assign tk_x     = 2'(fin_pat[3]) + 2'(fin_pat[2]);
  assign tk_y     = 2'(fin_pat[3]) + 2'(fin_pat[2]) + 2'(fin_pat[1]);

  always_comb begin
    quad_res             = '0;
    quad_res.kind        = ResQuad;
    quad_res.quad_index  = quads_done_q;
    if (fin_bl >= 14'sd0) begin
      quad_res.val_v = sign_val(fin_pat[3], fin_signs, fin_slot - 3'd1);
      quad_res.val_w = sign_val(fin_pat[2], fin_signs, fin_slot - 3'd1 - 3'(tk_w));
      quad_res.val_x = sign_val(fin_pat[1], fin_signs, fin_slot - 3'd1 - 3'(tk_x));
      quad_res.val_y = sign_val(fin_pat[0], fin_signs, fin_slot - 3'd1 - 3'(tk_y));
    end
  end

  // nonzero end, pair-rounded
  always_comb begin
    nz_end = {nz_cnt_q, 2'b00};
    if ((nz_pat_q[1:0] == 2'b00) && (nz_cnt_q != '0)) begin
      nz_end = {nz_cnt_q, 2'b00} - NzEndW'(2);
    end
    sum_res             = '0;
    sum_res.kind        = ResSummary;
    sum_res.nonzero_end = nz_end;
    sum_res.last        = 1'b1;
  end

  always_comb begin
    phase_d       = phase_q;
    use_b_d       = use_b_q;
    code_shift_d  = code_shift_q;
    code_len_d    = code_len_q;
    pattern_d     = pattern_q;
    sign_slot_d   = sign_slot_q;
    signs_d       = signs_q;
    bits_left_d   = bits_left_q;
    quads_done_d  = quads_done_q;
    quads_limit_d = quads_limit_q;
    nz_cnt_d      = nz_cnt_q;
    nz_pat_d      = nz_pat_q;
    fin           = 1'b0;
    res_wr_o      = '0;
    res_wr_o.first  = quad_res;
    res_wr_o.second = sum_res;

    if (go) begin
      if (cmd_i.kind == CmdStart) begin
        use_b_d       = cmd_i.table_b;
        bits_left_d   = signed'(14'(cmd_i.region_bits));
        quads_limit_d = cmd_i.quads_limit;
        quads_done_d  = '0;
        code_shift_d  = '0;
        code_len_d    = '0;
        pattern_d     = '0;
        sign_slot_d   = '0;
        signs_d       = '0;
        nz_cnt_d      = '0;
        nz_pat_d      = 4'hF;
        if (start_cont) begin
          phase_d = PhCode;
        end else begin
          phase_d                      = PhIdle;
          res_wr_o.first_vld           = 1'b1;
          res_wr_o.first               = '0;
          res_wr_o.first.kind          = ResSummary;
          res_wr_o.first.last          = 1'b1;
        end
      end else begin
        case (phase_q)
          PhCode: begin
            code_shift_d = cs_n;
            code_len_d   = len_n;
            if (code_done) begin
              pattern_d   = code_pat;
              bits_left_d = code_bl;
              sign_slot_d = '0;
              signs_d     = '0;
              if (code_pat != 4'h0) begin
                nz_cnt_d = qd_n;
                nz_pat_d = code_pat;
                phase_d  = PhSign;
              end else begin
                fin = 1'b1;
              end
            end
          end
          PhSign: begin
            signs_d     = sgn_n;
            sign_slot_d = slot_n;
            bits_left_d = fin_bl;
            if (slot_n >= ones_q) begin
              fin = 1'b1;
            end
          end
          default: begin
          end
        endcase

        if (fin) begin
          res_wr_o.first_vld = 1'b1;
          quads_done_d       = qd_n;
          code_shift_d       = '0;
          code_len_d         = '0;
          sign_slot_d        = '0;
          signs_d            = '0;
          if (fin_cont) begin
            phase_d = PhCode;
          end else begin
            phase_d             = PhIdle;
            res_wr_o.second_vld = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PhIdle;
      use_b_q       <= 1'b0;
      code_shift_q  <= '0;
      code_len_q    <= '0;
      pattern_q     <= '0;
      sign_slot_q   <= '0;
      signs_q       <= '0;
      bits_left_q   <= '0;
      quads_done_q  <= '0;
      quads_limit_q <= '0;
      nz_cnt_q      <= '0;
      nz_pat_q      <= 4'hF;
    end else begin
      phase_q       <= phase_d;
      use_b_q       <= use_b_d;
      code_shift_q  <= code_shift_d;
      code_len_q    <= code_len_d;
      pattern_q     <= pattern_d;
      sign_slot_q   <= sign_slot_d;
      signs_q       <= signs_d;
      bits_left_q   <= bits_left_d;
      quads_done_q  <= quads_done_d;
      quads_limit_q <= quads_limit_d;
      nz_cnt_q      <= nz_cnt_d;
      nz_pat_q      <= nz_pat_d;
    end
  end

endmodule

### hw/rtl/m3c1_resq.sv
`timescale 1ns / 1ps

module m3c1_resq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  m3c1_pkg::res_wr_t res_wr_i,
  output logic              res_room_o,
  output logic              empty,
  input  logic              pop,
  output m3c1_pkg::res_t    res_o
);
  import m3c1_pkg::*;

  localparam int unsigned PtrW = $clog2(ResDepth);
  localparam int unsigned CntW = $clog2(ResDepth + 1);

  res_t            mem_q [ResDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [PtrW-1:0] wr_ptr_p1;
  logic [1:0]      n_wr;
  logic            do_pop;

  assign empty      = (cnt_q == '0);
  assign do_pop     = pop && !empty;
  assign res_room_o = (cnt_q <= CntW'(ResDepth - 2));
  assign res_o      = mem_q[rd_ptr_q];
  assign wr_ptr_p1  = wr_ptr_q + 1'b1;
  assign n_wr       = 2'(res_wr_i.first_vld) + 2'(res_wr_i.second_vld);

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(n_wr);
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + CntW'(n_wr) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_wr_i.first_vld) begin
      mem_q[wr_ptr_q] <= res_wr_i.first;
    end
    if (res_wr_i.second_vld) begin
      mem_q[wr_ptr_p1] <= res_wr_i.second;
    end
  end

endmodule

### hw/rtl/mp3_count1_quad_decoder_core.sv
`timescale 1ns / 1ps
// MP3 layer III count1 region decoder, one bitstream bit per transaction.
// Input side is a queue: drive the item and push; it is taken when full is
// low. op 0 starts a region (table_b, region_bits, value_count); op 1 hands
// in one bit. A start aborts any region in progress; bits while idle drop.
// Result side is a queue: while empty is low the oldest result sits on the
// result ports and is taken with pop. kind 0 is a decoded quad, kind 1 the
// closing summary with nonzero_end and last set.
// Throughput: one item per cycle unless the engine holds. A small command
// queue parts the intake from the decode engine, a four-entry result queue
// parts the engine from the receiver. An item that closes a quad and the
// region writes two results at once; the engine holds an item while the
// result queue has fewer than two free slots, and the command queue then
// fills and raises full. A taken item is registered in the command queue,
// its results in the result queue, to be popped. Reset empties both queues
// and leaves the decoder idle; no region runs until the first start item.
module mp3_count1_quad_decoder_core #(
  parameter int unsigned MaxValues = m3c1_pkg::MaxValuesDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push,
  output logic                             full,
  input  logic                             op_i,
  input  logic                             bit_in_i,
  input  logic                             table_b_i,
  input  logic [m3c1_pkg::RegionBitsW-1:0] region_bits_i,
  input  logic [m3c1_pkg::ValueCountW-1:0] value_count_i,
  output logic                             empty,
  input  logic                             pop,
  output logic                             kind_o,
  output logic signed [1:0]                val_v_o,
  output logic signed [1:0]                val_w_o,
  output logic signed [1:0]                val_x_o,
  output logic signed [1:0]                val_y_o,
  output logic [m3c1_pkg::QuadW-1:0]       quad_index_o,
  output logic [m3c1_pkg::NzEndW-1:0]      nonzero_end_o,
  output logic                             last_o
);
  import m3c1_pkg::*;

  logic    cmd_vld;
  cmd_t    cmd;
  logic    cmd_pop;
  logic    res_room;
  res_wr_t res_wr;
  res_t    res;

  m3c1_front #(
    .MaxValues(MaxValues)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .op_i         (op_i),
    .bit_in_i     (bit_in_i),
    .table_b_i    (table_b_i),
    .region_bits_i(region_bits_i),
    .value_count_i(value_count_i),
    .cmd_vld_o    (cmd_vld),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  m3c1_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_vld_i (cmd_vld),
    .cmd_i     (cmd),
    .cmd_pop_o (cmd_pop),
    .res_room_i(res_room),
    .res_wr_o  (res_wr)
  );

  m3c1_resq u_resq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .res_wr_i  (res_wr),
    .res_room_o(res_room),
    .empty     (empty),
    .pop       (pop),
    .res_o     (res)
  );

  assign kind_o        = res.kind;
  assign val_v_o       = res.val_v;
  assign val_w_o       = res.val_w;
  assign val_x_o       = res.val_x;
  assign val_y_o       = res.val_y;
  assign quad_index_o  = res.quad_index;
  assign nonzero_end_o = res.nonzero_end;
  assign last_o        = res.last;

endmodule

### dv/tb_mp3_count1_quad_decoder_core.sv
`timescale 1ns / 1ps

module tb_mp3_count1_quad_decoder_core;
  import m3c1_pkg::*;

  localparam int MaxVals = MaxValuesDefault;

  typedef enum logic [1:0] {
    DecIdle,
    DecCode,
    DecSign
  } dec_phase_e;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   push = 1'b0;
  logic                   full;
  logic                   op_i = 1'b0;
  logic                   bit_in_i = 1'b0;
  logic                   table_b_i = 1'b0;
  logic [RegionBitsW-1:0] region_bits_i = '0;
  logic [ValueCountW-1:0] value_count_i = '0;
  logic                   empty;
  logic                   pop = 1'b0;
  logic                   kind_o;
  logic signed [1:0]      val_v_o;
  logic signed [1:0]      val_w_o;
  logic signed [1:0]      val_x_o;
  logic signed [1:0]      val_y_o;
  logic [QuadW-1:0]       quad_index_o;
  logic [NzEndW-1:0]      nonzero_end_o;
  logic                   last_o;

  mp3_count1_quad_decoder_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .op_i          (op_i),
    .bit_in_i      (bit_in_i),
    .table_b_i     (table_b_i),
    .region_bits_i (region_bits_i),
    .value_count_i (value_count_i),
    .empty         (empty),
    .pop           (pop),
    .kind_o        (kind_o),
    .val_v_o       (val_v_o),
    .val_w_o       (val_w_o),
    .val_x_o       (val_x_o),
    .val_y_o       (val_y_o),
    .quad_index_o  (quad_index_o),
    .nonzero_end_o (nonzero_end_o),
    .last_o        (last_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int errors = 0;

  res_t results_due[$];
  res_t want;

  dec_phase_e dec_phase = DecIdle;
  logic       use_tab_b = 1'b0;
  logic [5:0] code_bits = '0;
  int         code_len = 0;
  logic [3:0] quad_pat = '0;
  int         sign_cnt = 0;
  logic [3:0] sign_bits = '0;
  int         budget = 0;
  int         quad_cnt = 0;
  int         quad_max = 0;
  int         nz_quad = -1;
  logic [3:0] nz_pat = 4'hF;

  function automatic logic [7:0] tab_a_entry(logic [5:0] idx);
    case (idx)
      6'd0: return 8'h6B;
      6'd1: return 8'h6F;
      6'd2: return 8'h6D;
      6'd3: return 8'h6E;
      6'd4: return 8'h67;
      6'd5: return 8'h65;
      6'd6, 6'd7: return 8'h59;
      6'd8, 6'd9: return 8'h56;
      6'd10, 6'd11: return 8'h53;
      6'd12, 6'd13: return 8'h5A;
      6'd14, 6'd15: return 8'h5C;
      6'd16, 6'd17, 6'd18, 6'd19: return 8'h42;
      6'd20, 6'd21, 6'd22, 6'd23: return 8'h41;
      6'd24, 6'd25, 6'd26, 6'd27: return 8'h44;
      6'd28, 6'd29, 6'd30, 6'd31: return 8'h48;
      default: return 8'h10;
    endcase
  endfunction

  function automatic bit region_open();
    if (quad_cnt >= quad_max) return 1'b0;
    return use_tab_b ? (budget >= 4) : (budget > 0);
  endfunction

  task automatic emit_summary();
    res_t r;
    int   e;
    r = '0;
    e = (nz_quad + 1) * 4;
    if (nz_pat[1:0] == 2'b00 && e >= 2) e -= 2;
    r.kind = ResSummary;
    r.nonzero_end = e[NzEndW-1:0];
    r.last = 1'b1;
    results_due.push_back(r);
    dec_phase = DecIdle;
  endtask

  task automatic emit_quad();
    res_t              r;
    logic signed [1:0] vals[4];
    int                taken;
    taken = 0;
    for (int j = 0; j < 4; j++) begin
      if (quad_pat[3-j]) begin
        vals[j] = sign_bits[sign_cnt-1-taken] ? -2'sd1 : 2'sd1;
        taken++;
      end else begin
        vals[j] = 2'sd0;
      end
    end
    if (budget < 0) begin
      for (int j = 0; j < 4; j++) vals[j] = 2'sd0;
    end
    r = '0;
    r.kind = ResQuad;
    r.val_v = vals[0];
    r.val_w = vals[1];
    r.val_x = vals[2];
    r.val_y = vals[3];
    r.quad_index = quad_cnt[QuadW-1:0];
    results_due.push_back(r);
    quad_cnt++;
    code_bits = '0;
    code_len = 0;
    sign_cnt = 0;
    sign_bits = '0;
    if (budget < 0 || !region_open()) emit_summary();
    else dec_phase = DecCode;
  endtask

  task automatic decode_item(input cmd_kind_e op, input logic bitv, input logic tb,
                             input logic [RegionBitsW-1:0] rb,
                             input logic [ValueCountW-1:0] vc);
    int         vcc;
    logic [5:0] idx;
    logic [7:0] ent;
    bit         done;
    done = 1'b0;
    if (op == CmdStart) begin
      vcc = (int'(vc) > MaxVals) ? MaxVals : int'(vc);
      use_tab_b = tb;
      budget = int'(rb);
      quad_max = vcc >> 2;
      quad_cnt = 0;
      code_bits = '0;
      code_len = 0;
      quad_pat = '0;
      sign_cnt = 0;
      sign_bits = '0;
      nz_quad = -1;
      nz_pat = 4'hF;
      if (!region_open()) emit_summary();
      else dec_phase = DecCode;
    end else if (dec_phase == DecCode) begin
      code_bits = {code_bits[4:0], bitv};
      code_len++;
      if (use_tab_b) begin
        if (code_len >= 4) begin
          quad_pat = ~code_bits[3:0];
          budget -= 4;
          done = 1'b1;
        end
      end else begin
        idx = code_bits << (6 - code_len);
        ent = tab_a_entry(idx);
        if (int'(ent[7:4]) == code_len || code_len >= 6) begin
          quad_pat = ent[3:0];
          budget -= int'(ent[7:4]);
          done = 1'b1;
        end
      end
      if (done) begin
        if (quad_pat != 4'd0) begin
          nz_quad = quad_cnt;
          nz_pat = quad_pat;
        end
        sign_cnt = 0;
        sign_bits = '0;
        if (quad_pat == 4'd0) emit_quad();
        else dec_phase = DecSign;
      end
    end else if (dec_phase == DecSign) begin
      sign_bits = {sign_bits[2:0], bitv};
      sign_cnt++;
      budget--;
      if (sign_cnt >= $countones(quad_pat)) emit_quad();
    end
  endtask

  task automatic feed_item(input cmd_kind_e op, input logic bitv, input logic tb,
                           input logic [RegionBitsW-1:0] rb,
                           input logic [ValueCountW-1:0] vc);
    while ($urandom_range(99) < snd_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    op_i <= op;
    bit_in_i <= bitv;
    table_b_i <= tb;
    region_bits_i <= rb;
    value_count_i <= vc;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    decode_item(op, bitv, tb, rb, vc);
  endtask

  task automatic feed_bit(input logic b);
    feed_item(CmdBit, b, 1'($urandom_range(1)), 12'($urandom_range(4095)),
              10'($urandom_range(1023)));
  endtask

  task automatic feed_start(input logic tb, input int rb, input int vc);
    feed_item(CmdStart, 1'($urandom_range(1)), tb, rb[RegionBitsW-1:0],
              vc[ValueCountW-1:0]);
  endtask

  task automatic test_directed();
    feed_bit(1'b1);
    feed_bit(1'b0);
    feed_start(1'b0, 0, 576);
    feed_start(1'b0, 100, 3);
    feed_start(1'b1, 3, 100);
    feed_start(1'b0, 4095, 1023);
    feed_bit(1'b0);
    feed_bit(1'b0);
    feed_bit(1'b0);
    feed_bit(1'b0);
    feed_bit(1'b0);
    feed_bit(1'b1);
    feed_bit(1'b1);
    feed_bit(1'b0);
    feed_bit(1'b1);
    feed_bit(1'b0);
    feed_bit(1'b1);
    feed_start(1'b1, 6, 8);
    feed_bit(1'b0);
    feed_bit(1'b0);
    feed_bit(1'b0);
    feed_bit(1'b0);
    feed_bit(1'b0);
    feed_bit(1'b1);
    feed_bit(1'b1);
    feed_bit(1'b0);
  endtask

  task automatic test_full_region();
    feed_start(1'b0, 4095, 576);
    while (dec_phase != DecIdle) feed_bit(1'($urandom_range(1)));
  endtask

  task automatic test_result_backpressure();
    feed_start(1'b0, 4095, 576);
    hold_req = 1'b1;
    repeat (60) feed_bit(1'b1);
  endtask

  task automatic test_random_regions(input int n_items);
    int sent;
    int cap;
    int nbits;
    int rb;
    int vc;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 5) begin
        repeat ($urandom_range(1, 3)) feed_bit(1'($urandom_range(1)));
      end
      rb = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(60);
      vc = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(40);
      feed_start(1'($urandom_range(1)), rb, vc);
      sent++;
      cap = ($urandom_range(9) == 0) ? $urandom_range(1, 15) : 300;
      nbits = 0;
      while (dec_phase != DecIdle && nbits < cap) begin
        feed_bit(1'($urandom_range(1)));
        nbits++;
        sent++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  task automatic check_field(input string name, input logic signed [10:0] exp_val,
                             input logic signed [10:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t ns: %s expected %0d actual %0d", $time, name, exp_val, act_val);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (results_due.size() == 0) begin
        $display("%0t ns: transaction with no expectation, expected none actual kind %0d",
                 $time, kind_o);
        errors++;
      end else begin
        want = results_due.pop_front();
        check_field("kind", want.kind, kind_o);
        check_field("val_v", want.val_v, val_v_o);
        check_field("val_w", want.val_w, val_w_o);
        check_field("val_x", want.val_x, val_x_o);
        check_field("val_y", want.val_y, val_y_o);
        check_field("quad_index", want.quad_index, quad_index_o);
        check_field("nonzero_end", want.nonzero_end, nonzero_end_o);
        check_field("last", want.last, last_o);
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_region();
    test_result_backpressure();
    test_random_regions(340);
    snd_idle_pct = 86;
    rcv_stall_pct = 0;
    test_random_regions(340);
    snd_idle_pct = 0;
    rcv_stall_pct = 86;
    test_random_regions(340);
    snd_idle_pct = 20;
    rcv_stall_pct = 20;
    test_random_regions(340);
    push <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
